// File: sv/rdc_pkg.sv
// Shared types, constants and helper functions for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

    // Number format and digit widths
    localparam int INT_BITS            = 16;
    localparam int FRAC_BITS           = 32;
    localparam int BASE_W              = 8;
    localparam int COUNT_W             = 6;
    localparam int ACC_W               = FRAC_BITS + BASE_W;
    localparam int MAX_FRAC_DIGITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_COUNT  = 2'd1;

    // Register reset values and base limits
    localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd10;
    localparam logic [BASE_W-1:0]  BASE_MIN    = 8'd2;
    localparam logic [BASE_W-1:0]  MIXED_FROM  = 8'd62;

    // Result item kinds
    localparam logic [2:0] KIND_MINUS = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_POINT = 3'd2;
    localparam logic [2:0] KIND_FRAC  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // Character offsets for the digit alphabet
    localparam logic [BASE_W-1:0] CHAR_NUM_OFS   = 8'd48;
    localparam logic [BASE_W-1:0] CHAR_UPPER_OFS = 8'd55;
    localparam logic [BASE_W-1:0] CHAR_LOWER_OFS = 8'd61;
    localparam logic [BASE_W-1:0] LAST_NUM       = 8'd9;
    localparam logic [BASE_W-1:0] LAST_UPPER     = 8'd35;
    localparam logic [BASE_W-1:0] LAST_LOWER     = 8'd61;

    typedef struct packed {
        logic                 is_negative;
        logic [INT_BITS-1:0]  integer_magnitude;
        logic [FRAC_BITS-1:0] fraction_bits;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        item_kind;
        logic [BASE_W-1:0] digit_value;
        logic [6:0]        digit_char;
        logic              mixed_radix;
        logic              last;
    } t_out_item;

    typedef enum logic {
        ALU_DIV = 1'b0,
        ALU_MUL = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic                 start;
        t_alu_op              op;
        logic [INT_BITS-1:0]  quotient;
        logic [FRAC_BITS-1:0] fraction;
        logic [BASE_W-1:0]    base;
    } t_alu_req;

    typedef struct packed {
        logic                 done;
        logic [INT_BITS-1:0]  quotient;
        logic [BASE_W-1:0]    remainder;
        logic [BASE_W-1:0]    digit;
        logic [FRAC_BITS-1:0] fraction;
    } t_alu_rsp;

    // Map a digit to 0-9, A-Z, a-z; zero beyond the alphabet
    function automatic logic [6:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [BASE_W-1:0] c;
        if (d <= LAST_NUM) begin
            c = d + CHAR_NUM_OFS;
        end else if (d <= LAST_UPPER) begin
            c = d + CHAR_UPPER_OFS;
        end else if (d <= LAST_LOWER) begin
            c = d + CHAR_LOWER_OFS;
        end else begin
            c = '0;
        end
        return c[6:0];
    endfunction

endpackage

// File: sv/radix_digit_converter_top.sv
// Top level of the radix digit converter: configuration registers and core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one signed
//   fixed-point number. The output channel (o_out_valid / i_out_ready /
//   o_out_data) returns its run of items: optional minus, integer digits
//   most significant first, then radix point and fraction digits when the
//   fraction is nonzero; the final item carries last. A base below 2 gives
//   one error item. The configuration channel writes target_base (index 0)
//   and fraction_digit_count (index 1); it is always ready, and the user must
//   write it only while the converter is idle; the block does not enforce this.
//   Timing: one number at a time. Each integer digit is a 16-step
//   bit-serial division in the shared unit, each fraction digit an 8-step
//   shift-add multiply followed by its emit state, and each sign, point or
//   popped digit has its own state. The input is ready again once the last
//   item is in the output register.
//   A stalled receiver holds the current item and pauses the sequencer.
//   Reset (synchronous, active low) empties the output register, returns to
//   idle and sets base 10 with 10 fraction digits.
`timescale 1ns / 1ps

module radix_digit_converter_top
    import rdc_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [BASE_W-1:0]  r_target_base;
    logic [COUNT_W-1:0] r_frac_count;
    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    // Take configuration transfers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_base <= BASE_RESET;
            r_frac_count  <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARGET_BASE: r_target_base <= i_cfg_data;
                CFG_FRAC_COUNT:  r_frac_count  <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    rdc_seq #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .i_base       (r_target_base),
        .i_frac_count (r_frac_count),
        .o_alu_req    (alu_req),
        .i_alu_rsp    (alu_rsp)
    );

    rdc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

endmodule

// File: sv/rdc_alu.sv
// Shared bit-serial unit: restoring division and shift-add fraction multiply.
`timescale 1ns / 1ps

module rdc_alu
    import rdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int STEP_W = $clog2(INT_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_left;
    t_alu_op              r_op;
    logic [INT_BITS-1:0]  r_q;
    logic [BASE_W-1:0]    r_rem;
    logic [ACC_W-1:0]     r_acc;
    logic [FRAC_BITS-1:0] r_f;
    logic [BASE_W-1:0]    r_base;

    logic [BASE_W:0]      rem_shift;
    logic [ACC_W-1:0]     add_a;
    logic [ACC_W-1:0]     add_b;
    logic                 add_cin;
    logic [ACC_W-1:0]     sum;
    logic                 div_ge;

    // Pick adder operands: trial subtract for division, shift-add for multiply
    always_comb begin
        rem_shift = {r_rem, r_q[INT_BITS-1]};
        if (r_op == ALU_DIV) begin
            add_a   = ACC_W'(rem_shift);
            add_b   = ~ACC_W'(r_base);
            add_cin = 1'b1;
        end else begin
            add_a   = {r_acc[ACC_W-2:0], 1'b0};
            add_b   = r_base[BASE_W-1] ? ACC_W'(r_f) : '0;
            add_cin = 1'b0;
        end
        sum    = add_a + add_b + ACC_W'(add_cin);
        div_ge = ~sum[ACC_W-1];
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_left <= (i_req.op == ALU_DIV) ? STEP_W'(INT_BITS) : STEP_W'(BASE_W);
        end else if (r_busy) begin
            r_left <= r_left - STEP_W'(1);
            if (r_left == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Load operands, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_q    <= i_req.quotient;
            r_rem  <= '0;
            r_acc  <= '0;
            r_f    <= i_req.fraction;
            r_base <= i_req.base;
        end else if (r_busy) begin
            if (r_op == ALU_DIV) begin
                r_rem <= div_ge ? sum[BASE_W-1:0] : rem_shift[BASE_W-1:0];
                r_q   <= {r_q[INT_BITS-2:0], div_ge};
            end else begin
                r_acc  <= sum;
                r_base <= r_base << 1;
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;
    assign o_rsp.digit     = r_acc[ACC_W-1:FRAC_BITS];
    assign o_rsp.fraction  = r_acc[FRAC_BITS-1:0];

endmodule

// File: sv/rdc_seq.sv
// Sequencer: walks one number through sign, integer, point and fraction items.
`timescale 1ns / 1ps

module rdc_seq
    import rdc_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic [BASE_W-1:0]  i_base,
    input  logic [COUNT_W-1:0] i_frac_count,
    output t_alu_req           o_alu_req,
    input  t_alu_rsp           i_alu_rsp
);

    localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int N_W   = $clog2(INT_BITS + 1);
    localparam int IDX_W = $clog2(INT_BITS);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SIGN     = 10'b00_0000_0010,
        S_DIV_GO   = 10'b00_0000_0100,
        S_DIV_WAIT = 10'b00_0000_1000,
        S_POP      = 10'b00_0001_0000,
        S_ZERO     = 10'b00_0010_0000,
        S_POINT    = 10'b00_0100_0000,
        S_MUL_GO   = 10'b00_1000_0000,
        S_MUL_WAIT = 10'b01_0000_0000,
        S_FRAC     = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    logic                 r_neg, n_neg;
    logic [INT_BITS-1:0]  r_q, n_q;
    logic [FRAC_BITS-1:0] r_f, n_f;
    logic [BASE_W-1:0]    r_base, n_base;
    logic                 r_mixed, n_mixed;
    logic [CNT_W-1:0]     r_left, n_left;
    logic [N_W-1:0]       r_n, n_n;
    logic [BASE_W-1:0]    r_digit, n_digit;
    logic [BASE_W-1:0]    r_store [INT_BITS];

    logic                 out_free;
    logic                 st_we;
    logic [IDX_W-1:0]     st_idx;
    logic [N_W-1:0]       pop_n;
    logic [BASE_W-1:0]    pop_digit;
    logic [CNT_W-1:0]     count_sat;
    t_state               after_sign;

    always_comb begin
        out_free  = ~r_out_valid | i_out_ready;
        pop_n     = r_n - N_W'(1);
        pop_digit = r_store[pop_n[IDX_W-1:0]];
        st_idx    = r_n[IDX_W-1:0];

        // Clamp the fraction digit count
        if (32'(i_frac_count) > MAX_FRAC_DIGITS) begin
            count_sat = CNT_W'(MAX_FRAC_DIGITS);
        end else begin
            count_sat = CNT_W'(i_frac_count);
        end

        // Where to go once the sign is settled
        if (r_q != '0) begin
            after_sign = S_DIV_GO;
        end else if (!r_mixed) begin
            after_sign = S_ZERO;
        end else if (r_f != '0) begin
            after_sign = S_POINT;
        end else begin
            after_sign = S_IDLE;
        end

        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out       = r_out;
        n_neg       = r_neg;
        n_q         = r_q;
        n_f         = r_f;
        n_base      = r_base;
        n_mixed     = r_mixed;
        n_left      = r_left;
        n_n         = r_n;
        n_digit     = r_digit;
        st_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_neg   = i_in_data.is_negative;
                    n_q     = i_in_data.integer_magnitude;
                    n_f     = i_in_data.fraction_bits;
                    n_base  = i_base;
                    n_mixed = (i_base >= MIXED_FROM);
                    n_left  = count_sat;
                    n_n     = '0;
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_base < BASE_MIN) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{KIND_ERROR, '0, '0, 1'b0, 1'b1};
                        n_state     = S_IDLE;
                    end
                end else if (r_neg && (r_q != '0 || r_f != '0)) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{KIND_MINUS, '0, '0, r_mixed, 1'b0};
                        n_state     = after_sign;
                    end
                end else begin
                    n_state = after_sign;
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                // Push the remainder, continue while the quotient is nonzero
                if (i_alu_rsp.done) begin
                    st_we = 1'b1;
                    n_q   = i_alu_rsp.quotient;
                    n_n   = r_n + N_W'(1);
                    if (i_alu_rsp.quotient != '0 && r_n < N_W'(INT_BITS - 1)) begin
                        n_state = S_DIV_GO;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                // Emit stored digits most significant first
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{KIND_INT, pop_digit,
                              r_mixed ? 7'd0 : digit_to_char(pop_digit),
                              r_mixed, (r_n == N_W'(1)) && (r_f == '0)};
                    n_n = pop_n;
                    if (r_n == N_W'(1)) begin
                        n_state = (r_f != '0) ? S_POINT : S_IDLE;
                    end
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{KIND_INT, '0, digit_to_char('0), 1'b0, r_f == '0};
                    n_state = (r_f != '0) ? S_POINT : S_IDLE;
                end
            end
            S_POINT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out   = '{KIND_POINT, '0, '0, r_mixed, r_left == '0};
                    n_state = (r_left == '0) ? S_IDLE : S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_alu_rsp.done) begin
                    n_f     = i_alu_rsp.fraction;
                    n_digit = i_alu_rsp.digit;
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{KIND_FRAC, r_digit,
                              r_mixed ? 7'd0 : digit_to_char(r_digit),
                              r_mixed, r_left == CNT_W'(1)};
                    n_left  = r_left - CNT_W'(1);
                    n_state = (r_left == CNT_W'(1)) ? S_IDLE : S_MUL_GO;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_neg   <= n_neg;
        r_q     <= n_q;
        r_f     <= n_f;
        r_base  <= n_base;
        r_mixed <= n_mixed;
        r_left  <= n_left;
        r_n     <= n_n;
        r_digit <= n_digit;
        if (st_we) begin
            r_store[st_idx] <= i_alu_rsp.remainder;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_alu_req.start   = (r_state == S_DIV_GO) || (r_state == S_MUL_GO);
    assign o_alu_req.op      = (r_state == S_MUL_GO) ? ALU_MUL : ALU_DIV;
    assign o_alu_req.quotient = r_q;
    assign o_alu_req.fraction = r_f;
    assign o_alu_req.base    = r_base;

endmodule

// File: tb/sv/testbench.sv
// Testbench for the radix digit converter: directed table, then random phases against a predictor.
`timescale 1ns / 1ps

module testbench
    import rdc_pkg::*;
();

    localparam int HALF_NS      = 2;
    // Longest run is about 16 divisions and 32 multiplies in the shared unit
    localparam int DRAIN_CYCLES = 1000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 25;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [BASE_W-1:0]     base;
        logic [CFG_DATA_W-1:0] count;
        t_in_item              num;
        int                    n_want;   // below zero: use the predictor
        t_out_item [1:0]       want;
    } t_probe;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Settings as the converter should hold them
    logic [BASE_W-1:0]  radix_q      = BASE_RESET;
    logic [COUNT_W-1:0] frac_count_q = COUNT_RESET;

    t_out_item digit_q[$];
    t_probe    probes[$];
    int        mismatch_count = 0;
    int        items_checked  = 0;
    int        numbers_sent   = 0;
    int        settings_used  = 1;
    bit        send_gaps      = 1'b1;
    bit        recv_gaps      = 1'b1;
    bit        quiet          = 1'b0;
    bit        hold_req       = 1'b0;

    radix_digit_converter_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #HALF_NS clk = 1'b1;
        #HALF_NS clk = 1'b0;
    end

    // Digit alphabet: 0-9, A-Z, a-z
    function automatic logic [6:0] char_of_digit(input logic [7:0] d);
        if (d < 8'd10) return 7'(d + 8'd48);
        if (d < 8'd36) return 7'(d + 8'd55);
        if (d < 8'd62) return 7'(d + 8'd61);
        return 7'd0;
    endfunction

    function automatic t_out_item make_item(input logic [2:0] kind, input logic [7:0] val,
                                            input logic mixed);
        t_out_item it;
        it.item_kind   = kind;
        it.digit_value = val;
        it.digit_char  = ((kind == KIND_INT || kind == KIND_FRAC) && !mixed) ?
                         char_of_digit(val) : 7'd0;
        it.mixed_radix = mixed;
        it.last        = 1'b0;
        return it;
    endfunction

    // Work out the digit run of one number under the current settings
    function automatic void predict_digits(input t_in_item num);
        t_out_item      run[$];
        t_out_item      it;
        logic [7:0]     store [INT_BITS];
        logic [15:0]    quo;
        logic [31:0]    frac;
        logic [39:0]    prod;
        logic           mixed;
        int             n;
        int             digits;
        if (radix_q < BASE_MIN) begin
            it = make_item(KIND_ERROR, 8'd0, 1'b0);
            it.last = 1'b1;
            digit_q.push_back(it);
            return;
        end
        mixed = (radix_q >= MIXED_FROM);
        quo   = num.integer_magnitude;
        frac  = num.fraction_bits;
        // Minus only for a nonzero magnitude
        if (num.is_negative && (quo != 16'd0 || frac != 32'd0))
            run.push_back(make_item(KIND_MINUS, 8'd0, mixed));
        // Integer digits by repeated division, then most significant first
        if (quo == 16'd0) begin
            if (!mixed) run.push_back(make_item(KIND_INT, 8'd0, 1'b0));
        end else begin
            n = 0;
            while (quo != 16'd0) begin
                store[n] = 8'(quo % radix_q);
                quo      = quo / radix_q;
                n++;
            end
            for (int i = n - 1; i >= 0; i--)
                run.push_back(make_item(KIND_INT, store[i], mixed));
        end
        // Point and truncated fraction digits
        if (frac != 32'd0) begin
            digits = (frac_count_q > MAX_FRAC_DIGITS_DEF) ? MAX_FRAC_DIGITS_DEF : frac_count_q;
            run.push_back(make_item(KIND_POINT, 8'd0, mixed));
            for (int i = 0; i < digits; i++) begin
                prod = {8'd0, frac} * radix_q;
                run.push_back(make_item(KIND_FRAC, prod[39:32], mixed));
                frac = prod[31:0];
            end
        end
        if (run.size() > 0) begin
            it = run[run.size() - 1];
            it.last = 1'b1;
            run[run.size() - 1] = it;
        end
        foreach (run[i]) digit_q.push_back(run[i]);
    endfunction

    function automatic t_in_item rand_number();
        t_in_item num;
        num.is_negative = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       num.integer_magnitude = '0;
            1:       num.integer_magnitude = '1;
            2, 3:    num.integer_magnitude = 16'($urandom_range(0, 255));
            default: num.integer_magnitude = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0, 1:    num.fraction_bits = '0;
            2:       num.fraction_bits = '1;
            3:       num.fraction_bits = 32'($urandom_range(1, 15)) << $urandom_range(0, 28);
            default: num.fraction_bits = $urandom;
        endcase
        return num;
    endfunction

    function automatic void add_probe(input logic [7:0] base, input logic [7:0] count,
                                      input logic neg, input logic [15:0] mag,
                                      input logic [31:0] frac, input int n_want = -1,
                                      input t_out_item w0 = '0, input t_out_item w1 = '0);
        t_probe row;
        row.base    = base;
        row.count   = count;
        row.num     = '{neg, mag, frac};
        row.n_want  = n_want;
        row.want[0] = w0;
        row.want[1] = w1;
        probes.push_back(row);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("item %0d %s got %0d want %0d",
                                    items_checked, name, got, want));
    endtask

    // Offer one number and record its expected run on transfer
    task automatic offer_number(input t_in_item num, input int n_want,
                                input t_out_item [1:0] want);
        if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= num;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (n_want < 0) begin
            predict_digits(num);
        end else begin
            for (int i = 0; i < n_want; i++) digit_q.push_back(want[i]);
        end
        numbers_sent++;
        @(negedge clk);
    endtask

    // Hold off the input until every run is out and the sequencer has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (digit_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Leaves valid high so that back-to-back writes need no re-raise
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_TARGET_BASE: radix_q      = val;
            CFG_FRAC_COUNT:  frac_count_q = val[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_radix(input logic [7:0] base, input logic [7:0] count);
        wait_drained();
        write_reg(CFG_TARGET_BASE, base);
        write_reg(CFG_FRAC_COUNT, count);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Check each output transfer against the oldest expectation
    always @(posedge clk) begin : check_out
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (digit_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected item kind %0d value %0d",
                                        out_data.item_kind, out_data.digit_value));
            end else begin
                want = digit_q.pop_front();
                compare_field("item_kind", out_data.item_kind, want.item_kind);
                compare_field("digit_value", out_data.digit_value, want.digit_value);
                compare_field("digit_char", out_data.digit_char, want.digit_char);
                compare_field("mixed_radix", out_data.mixed_radix, want.mixed_radix);
                compare_field("last", out_data.last, want.last);
            end
            items_checked++;
        end
    end

    // Receiver: random stall bursts, and one long hold on request
    initial begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (recv_gaps && !quiet && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        t_out_item       zero_last;
        t_out_item       err_item;
        t_out_item       one_digit;
        t_out_item       point_last;
        logic [7:0]      base;
        logic [7:0]      count;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        zero_last  = '{KIND_INT, 8'd0, 7'd48, 1'b0, 1'b1};
        err_item   = '{KIND_ERROR, 8'd0, 7'd0, 1'b0, 1'b1};
        one_digit  = '{KIND_INT, 8'd1, 7'd49, 1'b0, 1'b0};
        point_last = '{KIND_POINT, 8'd0, 7'd0, 1'b0, 1'b1};

        // Extremes, special cases and every item kind
        add_probe(8'd10, 8'd10, 1'b0, 16'd0, 32'd0, 1, zero_last);
        add_probe(8'd10, 8'd10, 1'b1, 16'd0, 32'd0, 1, zero_last);   // negative zero
        add_probe(8'd10, 8'd10, 1'b0, 16'hFFFF, 32'd0);
        add_probe(8'd10, 8'd10, 1'b1, 16'd1, 32'h8000_0000);
        add_probe(8'd10, 8'd10, 1'b0, 16'd0, 32'hFFFF_FFFF);
        add_probe(8'd0, 8'd10, 1'b1, 16'd5, 32'h1234_5678, 1, err_item);
        add_probe(8'd1, 8'd10, 1'b0, 16'd0, 32'd0, 1, err_item);
        add_probe(8'd2, 8'd0, 1'b0, 16'd1, 32'd1, 2, one_digit, point_last);
        add_probe(8'd2, 8'd32, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);          // longest run
        add_probe(8'd2, 8'hFF, 1'b1, 16'd0, 32'd1);                      // count saturates
        add_probe(8'd3, 8'd40, 1'b0, 16'd12345, 32'h1234_5678);
        add_probe(8'd16, 8'd8, 1'b0, 16'hBEEF, 32'hDEAD_BEEF);
        add_probe(8'd36, 8'd5, 1'b1, 16'd35, 32'hAAAA_5555);
        add_probe(8'd61, 8'd6, 1'b0, 16'd60, 32'h7FFF_FFFF);
        add_probe(8'd61, 8'd4, 1'b0, 16'd0, 32'd0, 1, zero_last);
        add_probe(8'd62, 8'd3, 1'b0, 16'd0, 32'd0, 0);                  // empty run
        add_probe(8'd62, 8'd3, 1'b1, 16'd0, 32'd0, 0);
        add_probe(8'd62, 8'd3, 1'b0, 16'd0, 32'h4000_0000);
        add_probe(8'd62, 8'd3, 1'b1, 16'd61, 32'd0);
        add_probe(8'd255, 8'd32, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        add_probe(8'd255, 8'd1, 1'b1, 16'd0, 32'h8000_0000);
        add_probe(8'd10, 8'd10, 1'b0, 16'd100, 32'd0);

        // Hold reset, then release it
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // A write to the spare index must leave the reset settings alone
        write_reg(CFG_SPARE, 8'($urandom));
        cfg_valid <= 1'b0;

        // Walk the directed table
        foreach (probes[r]) begin
            if (probes[r].base != radix_q || probes[r].count[COUNT_W-1:0] != frac_count_q)
                set_radix(probes[r].base, probes[r].count);
            offer_number(probes[r].num, probes[r].n_want, probes[r].want);
        end

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:       base = 8'($urandom_range(0, 1));
                1:       base = 8'd2;
                2:       base = 8'd255;
                3:       base = 8'($urandom_range(61, 62));
                4, 5:    base = 8'($urandom_range(62, 255));
                default: base = 8'($urandom_range(2, 61));
            endcase
            count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                                  8'($urandom_range(0, 12));
            if (p == PHASES - 1) base = 8'($urandom_range(2, 255));
            set_radix(base, count);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            quiet     = (p == PHASES - 1);
            // Starve the output so the converter backs up onto its input
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer_number(rand_number(), -1, '0);
        end

        wait_drained();
        $display("Summary: %0d numbers in, %0d digit items checked, %0d radix settings used.",
                 numbers_sent, items_checked, settings_used);
        $display("Covered bad bases, both digit modes, count saturation, stalls and a long hold.");
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a time limit several times the slowest clean run
    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
